// ===== src/stffi_pkg.sv =====
`default_nettype none

package stffi_pkg;

    localparam int STFFI_SLOTS_DEF = 64;
    localparam int ID_W            = 16;
    localparam int IDX_W           = 8;
    localparam int FUNC_W          = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_STORE = 2'd0,
        FN_READ  = 2'd1,
        FN_FIND  = 2'd2,
        FN_COUNT = 2'd3
    } t_func;

endpackage

`default_nettype wire

// ===== src/stffi_if.sv =====
`default_nettype none

interface stffi_req_if import stffi_pkg::*;;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [IDX_W-1:0]    index;
    logic [ID_W-1:0]     item_id;

    modport source (output valid, output func, output index, output item_id, input ready);
    modport sink   (input valid, input func, input index, input item_id, output ready);
endinterface

interface stffi_rsp_if import stffi_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [ID_W-1:0]         item_out;
    logic signed [IDX_W-1:0] position;
    logic [IDX_W-1:0]        filled;
    logic                    stored;

    modport source (output valid, output item_out, output position, output filled,
                    output stored, input ready);
    modport sink   (input valid, input item_out, input position, input filled,
                    input stored, output ready);
endinterface

`default_nettype wire

// ===== src/stffi_ram.sv =====
`default_nettype none

module stffi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/slot_table_first_free_insert.sv =====
`default_nettype none

// store, find and count sweep the whole table, one slot read per cycle,
// through the single ram read port, while read fetches only its own slot;
// an item is accepted only in idle, and the next waits until the last one
// has left its done state; a stalled result holds the next item there
// reset clears a valid bit per slot at once, so the table reads empty with no
// clearing pass; a new item is taken while an earlier result still waits
module slot_table_first_free_insert import stffi_pkg::*; #(
    parameter int TABLE_SLOTS = STFFI_SLOTS_DEF
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    stffi_req_if.sink    i_req,
    stffi_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [IDX_W-1:0] SlotsIdx = IDX_W'(TABLE_SLOTS);
    localparam logic [AW-1:0]    LastAddr = AW'(TABLE_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DONE
    } t_state;

    t_state                  r_state;
    t_func                   r_func;
    logic [IDX_W-1:0]        r_idx;
    logic [ID_W-1:0]         r_id;
    logic [AW-1:0]           r_raddr;
    logic                    r_dv;
    logic [AW-1:0]           r_daddr;
    logic [TABLE_SLOTS-1:0]  r_valid;
    logic                    r_req_ok;
    logic                    r_free_found;
    logic [AW-1:0]           r_free_addr;
    logic                    r_found;
    logic [AW-1:0]           r_pos;
    logic [CW-1:0]           r_cnt;
    logic [ID_W-1:0]         r_rdata;
    logic                    r_ovalid;
    logic [ID_W-1:0]         r_item_out;
    logic signed [IDX_W-1:0] r_position;
    logic [IDX_W-1:0]        r_filled;
    logic                    r_stored;

    logic [ID_W-1:0]         w_ram_q;
    logic [ID_W-1:0]         w_v;
    logic                    w_req_use;
    logic [AW-1:0]           w_idx_a;
    logic                    w_out_free;
    logic                    w_hit;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic                    w_accept;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_idx_a    = r_idx[AW-1:0];
    assign w_req_use  = (r_idx != '0) && (r_idx < SlotsIdx);
    assign w_v        = r_valid[r_daddr] ? w_ram_q : '0;
    assign w_out_free = !r_ovalid || o_rsp.ready;
    assign w_hit      = r_req_ok || r_free_found;
    assign w_waddr    = r_req_ok ? w_idx_a : r_free_addr;
    assign w_we       = (r_state == S_DONE) && w_out_free && (r_func == FN_STORE) && w_hit;

    stffi_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_id),
        .i_raddr (r_raddr),
        .o_rdata (w_ram_q)
    );

    // per-item accumulation over the returning slot data
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func       <= t_func'(i_req.func);
            r_idx        <= i_req.index;
            r_id         <= i_req.item_id;
            r_req_ok     <= 1'b0;
            r_free_found <= 1'b0;
            r_found      <= 1'b0;
            r_cnt        <= '0;
        end else if (r_dv) begin
            if (r_daddr == w_idx_a && w_req_use && w_v == '0) begin
                r_req_ok <= 1'b1;
            end
            if (r_daddr != '0 && w_v == '0 && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_addr  <= r_daddr;
            end
            if (w_v == r_id && !r_found) begin
                r_found <= 1'b1;
                r_pos   <= r_daddr;
            end
            if (w_v != '0) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_rdata <= w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dv     <= 1'b0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_dv     <= (r_state == S_ISSUE);
            r_ovalid <= ((r_state == S_DONE) && w_out_free) || (r_ovalid && !o_rsp.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_raddr <= (t_func'(i_req.func) == FN_READ) ? i_req.index[AW-1:0] : '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_daddr <= r_raddr;
                    if (r_func == FN_READ || r_raddr == LastAddr) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_raddr <= r_raddr + 1'b1;
                    end
                end
                S_WAIT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_item_out <= (r_func == FN_READ && r_idx < SlotsIdx) ? r_rdata : '0;
                        r_position <= (r_func != FN_FIND) ? '0 :
                                      (r_found ? IDX_W'(r_pos) : '1);
                        r_filled   <= (r_func == FN_COUNT) ? IDX_W'(r_cnt) : '0;
                        r_stored   <= (r_func == FN_STORE) && w_hit;
                        if (w_we) begin
                            r_valid[w_waddr] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.item_out = r_item_out;
    assign o_rsp.position = r_position;
    assign o_rsp.filled   = r_filled;
    assign o_rsp.stored   = r_stored;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import stffi_pkg::*;

    localparam int TABLE_SLOTS    = STFFI_SLOTS_DEF;
    localparam int RANDOM_ITEMS   = 1380;
    localparam int FILL_FROM      = 900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_DIRECTED     = 21;

    typedef struct packed {
        t_func            func;
        logic [IDX_W-1:0] index;
        logic [ID_W-1:0]  item_id;
    } table_req_t;

    typedef struct packed {
        logic [ID_W-1:0]  item_out;
        logic [IDX_W-1:0] position;
        logic [IDX_W-1:0] filled;
        logic             stored;
    } table_rsp_t;

    typedef struct {
        table_req_t req;
        bit         fixed;
        table_rsp_t want;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stffi_req_if req_if ();
    stffi_rsp_if rsp_if ();

    slot_table_first_free_insert #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    logic [ID_W-1:0] slot_ids [TABLE_SLOTS];
    table_rsp_t      table_answers_due [$];
    int              bad_fields  = 0;
    int              burst_left  = 0;
    int              idle_cycles = 0;
    int unsigned     rdy_cycle   = 0;

    // fixed answers only where the empty or nearly empty table or an out of range slot makes them obvious
    dir_row_t dir_rows [N_DIRECTED] = '{
        '{'{FN_COUNT, 8'd0,   16'h0000}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b0}},
        '{'{FN_READ,  8'd0,   16'h0000}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b0}},
        '{'{FN_READ,  8'd255, 16'hffff}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b0}},
        '{'{FN_FIND,  8'd0,   16'h0000}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b0}},
        '{'{FN_FIND,  8'd255, 16'hffff}, 1'b1, '{16'h0000, 8'hff, 8'd0, 1'b0}},
        '{'{FN_STORE, 8'd0,   16'h1234}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b1}},
        '{'{FN_STORE, 8'd63,  16'hffff}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b1}},
        '{'{FN_STORE, 8'd64,  16'h8000}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b1}},
        '{'{FN_STORE, 8'd255, 16'h0001}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b1}},
        '{'{FN_STORE, 8'd63,  16'h5555}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b1}},
        '{'{FN_STORE, 8'd10,  16'h0000}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b1}},
        '{'{FN_READ,  8'd63,  16'h0000}, 1'b0, '0},
        '{'{FN_READ,  8'd64,  16'h0000}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b0}},
        '{'{FN_READ,  8'd1,   16'h0000}, 1'b0, '0},
        '{'{FN_READ,  8'd2,   16'h0000}, 1'b0, '0},
        '{'{FN_FIND,  8'd0,   16'hffff}, 1'b0, '0},
        '{'{FN_FIND,  8'd0,   16'h5555}, 1'b0, '0},
        '{'{FN_FIND,  8'd7,   16'h0000}, 1'b1, '{16'h0000, 8'h00, 8'd0, 1'b0}},
        '{'{FN_COUNT, 8'd128, 16'haaaa}, 1'b0, '0},
        '{'{FN_READ,  8'd10,  16'h0000}, 1'b0, '0},
        '{'{FN_STORE, 8'd1,   16'haaaa}, 1'b0, '0}
    };

    function automatic table_rsp_t table_apply(table_req_t r);
        table_rsp_t res;
        int         hit;
        int         k;
        res = '0;
        case (r.func)
            FN_STORE: begin
                hit = -1;
                if (r.index > 0 && r.index < TABLE_SLOTS && slot_ids[r.index] == '0) begin
                    hit = int'(r.index);
                end else begin
                    for (k = 1; k < TABLE_SLOTS; k++) begin
                        if (hit < 0 && slot_ids[k] == '0) hit = k;
                    end
                end
                if (hit >= 0) begin
                    slot_ids[hit] = r.item_id;
                    res.stored = 1'b1;
                end
            end
            FN_READ: begin
                if (r.index < TABLE_SLOTS) res.item_out = slot_ids[r.index];
            end
            FN_FIND: begin
                res.position = 8'hff;
                for (k = TABLE_SLOTS - 1; k >= 0; k--) begin
                    if (slot_ids[k] == r.item_id) res.position = k[IDX_W-1:0];
                end
            end
            default: begin
                for (k = 0; k < TABLE_SLOTS; k++) begin
                    if (slot_ids[k] != '0) res.filled = res.filled + 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    task automatic send_item(input table_req_t r, input bit fixed, input table_rsp_t want);
        table_rsp_t predicted;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= r.func;
        req_if.index   <= r.index;
        req_if.item_id <= r.item_id;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = table_apply(r);
        table_answers_due.push_back(fixed ? want : predicted);
        burst_left--;
        if (burst_left == 0) req_if.valid <= 1'b0;
    endtask

    // receiver: always ready, random stalls, long stalls, short periodic stalls
    always @(posedge i_clk) begin
        rdy_cycle <= rdy_cycle + 1;
        case ((rdy_cycle >> 9) % 4)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= ((rdy_cycle % 97) >= 60);
            default: rsp_if.ready <= ((rdy_cycle % 5) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid && rsp_if.ready) begin
            if (table_answers_due.size() == 0) begin
                $error("result item with nothing expected");
                bad_fields++;
            end else begin
                table_rsp_t want;
                want = table_answers_due.pop_front();
                if (rsp_if.item_out !== want.item_out) begin
                    $error("item_out: expected %h, got %h", want.item_out, rsp_if.item_out);
                    bad_fields++;
                end
                if (rsp_if.position !== want.position) begin
                    $error("position: expected %0d, got %0d",
                           $signed(want.position), $signed(rsp_if.position));
                    bad_fields++;
                end
                if (rsp_if.filled !== want.filled) begin
                    $error("filled: expected %0d, got %0d", want.filled, rsp_if.filled);
                    bad_fields++;
                end
                if (rsp_if.stored !== want.stored) begin
                    $error("stored: expected %0d, got %0d", want.stored, rsp_if.stored);
                    bad_fields++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int              n;
        int              store_pct;
        logic [ID_W-1:0] id_any;
        table_req_t      r;
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.func    <= FN_STORE;
        req_if.index   <= '0;
        req_if.item_id <= '0;
        foreach (slot_ids[k]) slot_ids[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < N_DIRECTED; n++) begin
            send_item(dir_rows[n].req, dir_rows[n].fixed, dir_rows[n].want);
        end

        // sparse stores first to work a partly filled table, then fill it up
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            store_pct = (n < FILL_FROM) ? 10 : 45;
            if ($urandom_range(0, 99) < store_pct) begin
                r.func = FN_STORE;
            end else begin
                case ($urandom_range(0, 2))
                    0: r.func = FN_READ;
                    1: r.func = FN_FIND;
                    default: r.func = FN_COUNT;
                endcase
            end
            r.index = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 255))
                                                  : IDX_W'($urandom_range(0, TABLE_SLOTS - 1));
            if ($urandom_range(0, 7) == 0) id_any = '0;
            else if ($urandom_range(0, 2) == 0) id_any = ID_W'($urandom_range(1, 8));
            else id_any = ID_W'($urandom_range(0, 65535));
            if (r.func == FN_FIND && $urandom_range(0, 1) == 0) begin
                id_any = slot_ids[$urandom_range(0, TABLE_SLOTS - 1)];
            end
            r.item_id = id_any;
            send_item(r, 1'b0, '0);
        end
        if (burst_left != 0) req_if.valid <= 1'b0;

        while (table_answers_due.size() != 0) @(posedge i_clk);
        repeat (TABLE_SLOTS + 8) @(posedge i_clk);
        if (bad_fields == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
